// ----- design/gsp_pkg.sv -----
// ----------------------------------------------------------------------------
// GPS satellite position package
// Shared payload types, unit request and response structs, sequencer states,
// fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int unsigned KEPLER_MAX_ITER_DEF = 16;
    localparam int unsigned CORDIC_STAGES_DEF   = 32;

    localparam int TRIG_W = 40;
    typedef logic signed [TRIG_W-1:0] t_trig;

    localparam logic signed [32:0] HALF_WEEK_T    = 33'sd309657600;
    localparam logic signed [32:0] WEEK_T         = 33'sd619315200;
    localparam logic [39:0]        CORDIC_GAIN_Q30 = 40'd652032874;
    localparam logic [63:0]        INV_PI_Q32      = 64'd1367130551;
    localparam logic [31:0]        PERIGEE_ARG     = 32'd356027126;
    localparam logic [63:0]        NODE_RATE_Q32   = 64'd209094235300;
    localparam logic [63:0]        EARTH_RATE_Q32  = 64'd214088516000000;

    // Dividend of the mean-motion division: the scaled root of mu over pi.
    localparam int              DIV_NUM_W = 101;
    localparam logic [DIV_NUM_W-1:0] DIV_NUM = {43'd6663754060321, 58'd0};

    typedef struct packed {
        logic        [29:0] time_of_week;
        logic        [19:0] reference_time;
        logic signed [31:0] mean_anomaly;
        logic        [23:0] root_semi_axis;
        logic        [15:0] eccentricity;
        logic signed [31:0] inclination;
        logic signed [31:0] node_longitude;
    } t_gsp_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               converged;
    } t_gsp_out;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic signed [127:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic        vect;
        logic [31:0] ang;
        t_trig       x;
        t_trig       y;
    } t_cor_req;

    typedef struct packed {
        logic        done;
        t_trig       x;
        t_trig       y;
        logic [31:0] z;
    } t_cor_rsp;

    typedef struct packed {
        logic        start;
        logic        sqrt;
        logic [71:0] den;
        logic [63:0] rad;
    } t_ds_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } t_ds_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_MM1, S_MM2, S_DIV, S_MA, S_KROT, S_KMUL1, S_KMUL2, S_FROT,
        S_SQ1, S_SQRT, S_SQ2, S_VEC, S_F1, S_R, S_N1, S_N2, S_ROTU, S_ROTI,
        S_ROTL, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_OUT
    } t_gsp_state;

    function automatic logic [29:0] atan_entry(input logic [5:0] idx);
        logic [29:0] v;
        unique case (idx)
            6'd0:  v = 30'd536870912;
            6'd1:  v = 30'd316933406;
            6'd2:  v = 30'd167458907;
            6'd3:  v = 30'd85004756;
            6'd4:  v = 30'd42667331;
            6'd5:  v = 30'd21354465;
            6'd6:  v = 30'd10679838;
            6'd7:  v = 30'd5340245;
            6'd8:  v = 30'd2670163;
            6'd9:  v = 30'd1335087;
            6'd10: v = 30'd667544;
            6'd11: v = 30'd333772;
            6'd12: v = 30'd166886;
            6'd13: v = 30'd83443;
            6'd14: v = 30'd41722;
            6'd15: v = 30'd20861;
            6'd16: v = 30'd10430;
            6'd17: v = 30'd5215;
            6'd18: v = 30'd2608;
            6'd19: v = 30'd1304;
            6'd20: v = 30'd652;
            6'd21: v = 30'd326;
            6'd22: v = 30'd163;
            6'd23: v = 30'd81;
            6'd24: v = 30'd41;
            6'd25: v = 30'd20;
            6'd26: v = 30'd10;
            6'd27: v = 30'd5;
            6'd28: v = 30'd3;
            6'd29: v = 30'd1;
            6'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/gsp_mul.sv -----
// ----------------------------------------------------------------------------
// GPS satellite position shared multiplier
// Signed 64 by 64 multiply, one 16-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module gsp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsp_pkg::t_mul_req i_req,
    output gsp_pkg::t_mul_rsp o_rsp
);
    import gsp_pkg::*;

    logic signed [63:0]  r_a;
    logic        [63:0]  r_b;
    logic signed [127:0] r_acc;
    logic        [1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;

    logic signed [16:0]  w_dig;
    logic signed [80:0]  w_part;

    // Horner order from the top digit, which is the only signed one.
    assign w_dig  = (r_cnt == 2'd0) ? {r_b[63], r_b[63:48]} : {1'b0, r_b[63:48]};
    assign w_part = r_a * w_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            r_b <= {r_b[47:0], 16'd0};
            if (r_cnt == 2'd0) begin
                r_acc <= 128'(w_part);
            end else begin
                r_acc <= (r_acc <<< 16) + 128'(w_part);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

// ----- design/gsp_cordic.sv -----
// ----------------------------------------------------------------------------
// GPS satellite position CORDIC
// Iterative rotation (sine and cosine) and vectoring (arctangent) unit,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module gsp_cordic #(
    parameter int unsigned CORDIC_STAGES = gsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsp_pkg::t_cor_req i_req,
    output gsp_pkg::t_cor_rsp o_rsp
);
    import gsp_pkg::*;

    localparam int IW = $clog2(CORDIC_STAGES);

    logic [IW-1:0]      r_i;
    logic               r_busy;
    logic               r_done;
    logic               r_vect;
    logic               r_flip;
    t_trig              r_x;
    t_trig              r_y;
    logic signed [33:0] r_z;

    t_trig              w_dx;
    t_trig              w_dy;
    logic               w_sigma;
    logic signed [33:0] w_at;
    logic [31:0]        w_ang_q;
    logic               w_rflip;
    logic [31:0]        w_ang2;

    assign w_dx    = r_y >>> r_i;
    assign w_dy    = r_x >>> r_i;
    assign w_at    = $signed({4'd0, atan_entry(6'(r_i))});
    assign w_sigma = r_vect ? r_y[TRIG_W-1] : !r_z[33];

    // Angles in the left half plane are turned by half a circle first.
    assign w_ang_q = i_req.ang + 32'h4000_0000;
    assign w_rflip = w_ang_q[31];
    assign w_ang2  = w_rflip ? i_req.ang + 32'h8000_0000 : i_req.ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(CORDIC_STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vect <= i_req.vect;
            if (i_req.vect) begin
                r_flip <= i_req.x[TRIG_W-1];
                r_x    <= i_req.x[TRIG_W-1] ? -i_req.x : i_req.x;
                r_y    <= i_req.x[TRIG_W-1] ? -i_req.y : i_req.y;
                r_z    <= '0;
            end else begin
                r_flip <= w_rflip;
                r_x    <= $signed(CORDIC_GAIN_Q30);
                r_y    <= '0;
                r_z    <= 34'($signed(w_ang2));
            end
        end else if (r_busy) begin
            if (w_sigma) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = (r_flip && !r_vect) ? -r_x : r_x;
    assign o_rsp.y    = (r_flip && !r_vect) ? -r_y : r_y;
    assign o_rsp.z    = r_z[31:0] + ((r_flip && r_vect) ? 32'h8000_0000 : 32'd0);

endmodule

// ----- design/gsp_divsqrt.sv -----
// ----------------------------------------------------------------------------
// GPS satellite position divider and square root
// Restoring division with saturation and bitwise integer square root,
// one quotient or root bit per cycle on a shared counter.
// ----------------------------------------------------------------------------
module gsp_divsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gsp_pkg::t_ds_req i_req,
    output gsp_pkg::t_ds_rsp o_rsp
);
    import gsp_pkg::*;

    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic [71:0] r_den;
    logic [71:0] r_rem;
    logic [63:0] r_q;
    logic        r_over;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;

    logic [72:0] w_rem_sh;
    logic        w_dge;
    logic [63:0] w_sum;
    logic        w_sge;

    assign w_rem_sh = {r_rem, DIV_NUM[r_cnt]};
    assign w_dge    = w_rem_sh >= {1'b0, r_den};
    assign w_sum    = r_res + r_bit;
    assign w_sge    = r_v >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.sqrt ? 7'd31 : 7'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
            r_v    <= i_req.rad;
            r_res  <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_sqrt) begin
                if (w_sge) begin
                    r_v   <= r_v - w_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                // A zero divisor sets every high quotient bit and so saturates.
                r_rem <= w_dge ? 72'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[71:0];
                if (w_dge) begin
                    if (r_cnt >= 7'd64) begin
                        r_over <= 1'b1;
                    end else begin
                        r_q[r_cnt[5:0]] <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_sqrt ? r_res : (r_over ? '1 : r_q);

endmodule

// ----- design/gps_satellite_position_core.sv -----
// ----------------------------------------------------------------------------
// GPS satellite position core
// Earth-fixed satellite position from almanac terms and a time of week.
// ----------------------------------------------------------------------------
// The input channel takes one beat per satellite: time of week, reference
// epoch and the almanac orbit terms. The output channel returns one beat with
// the saturated X, Y and Z position and the Kepler converged flag.
// Both channels use valid and stall; a beat moves on an edge with valid high
// and stall low. The core holds o_in_stall high while it works on a beat.
// The time to a result is set by the single CORDIC unit, which runs once per
// Kepler update (1 to KEPLER_MAX_ITER of them) and five more times, by the
// one-bit-per-cycle mean-motion divider, the square root and by seventeen
// fixed passes plus two per Kepler update through the shared multiplier.
// The next input beat can be taken in the cycle in which the result appears.
// The result sits in an output register; a new input beat is taken while it
// waits, but the core will not overwrite it until the receiver takes it, so a
// stalled receiver eventually stalls the input side too.
// Reset is synchronous and clears the sequencer, the units and the output
// valid; no result is pending after reset.
// ----------------------------------------------------------------------------
module gps_satellite_position_core #(
    parameter int unsigned KEPLER_MAX_ITER = gsp_pkg::KEPLER_MAX_ITER_DEF,
    parameter int unsigned CORDIC_STAGES   = gsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gsp_pkg::t_gsp_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gsp_pkg::t_gsp_out o_out_data
);
    import gsp_pkg::*;

    localparam int KW = $clog2(KEPLER_MAX_ITER);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Sequencer control.
    t_gsp_state r_state, n_state;
    logic       r_issued;
    logic       r_out_valid;
    t_gsp_out   r_out;

    // Operands and intermediate results of one beat.
    t_gsp_in            r_in;
    logic signed [31:0] r_tk;
    logic [47:0]        r_s2;
    logic [71:0]        r_s3;
    logic [63:0]        r_n;
    logic [31:0]        r_m;
    logic [31:0]        r_ek;
    logic [KW-1:0]      r_iter;
    logic               r_conv;
    t_trig              r_ce;
    t_trig              r_se;
    logic signed [63:0] r_p14;
    logic [63:0]        r_rad;
    logic [31:0]        r_sq;
    t_trig              r_vy;
    logic [31:0]        r_uk;
    logic [31:0]        r_f;
    logic [31:0]        r_r;
    logic [63:0]        r_acc;
    logic [31:0]        r_lam;
    t_trig              r_cu;
    t_trig              r_su;
    t_trig              r_ci;
    t_trig              r_si;
    t_trig              r_cl;
    t_trig              r_sl;
    t_trig              r_xp;
    t_trig              r_yp;
    t_trig              r_yc;
    logic signed [63:0] r_t;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_cor_req cor_req;
    t_cor_rsp cor_rsp;
    t_ds_req  ds_req;
    t_ds_rsp  ds_rsp;

    logic               w_accept;
    logic               w_done;
    logic               w_load;
    logic signed [63:0] w_lo;
    logic [31:0]        w_kterm;
    logic [31:0]        w_next;
    logic signed [32:0] w_tk0;
    logic signed [32:0] w_tk;
    logic signed [63:0] w_f;
    logic [63:0]        w_acc;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_sum;

    gsp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    gsp_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    gsp_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .o_rsp   (ds_rsp)
    );

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_done   = mul_rsp.done || cor_rsp.done || ds_rsp.done;
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign w_lo     = mul_rsp.p[63:0];

    // Kepler update: the eccentricity term is folded back into semicircles.
    assign w_kterm  = 32'(w_lo >>> 38);
    assign w_next   = r_m + w_kterm;

    // Time from the epoch, pulled back inside half a week once.
    assign w_tk0 = $signed({3'd0, i_in_data.time_of_week})
                 - $signed({3'd0, i_in_data.reference_time, 10'd0});
    always_comb begin
        if (w_tk0 > HALF_WEEK_T) begin
            w_tk = w_tk0 - WEEK_T;
        end else if (w_tk0 < -HALF_WEEK_T) begin
            w_tk = w_tk0 + WEEK_T;
        end else begin
            w_tk = w_tk0;
        end
    end

    assign w_f    = 64'sd1073741824 - (w_lo >>> 21);
    assign w_acc  = 64'd0 - r_acc - w_lo;
    assign w_diff = r_t - w_lo;
    assign w_sum  = r_t + w_lo;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MM1;
            S_MM1:   if (w_done) n_state = S_MM2;
            S_MM2:   if (w_done) n_state = S_DIV;
            S_DIV:   if (w_done) n_state = S_MA;
            S_MA:    if (w_done) n_state = S_KROT;
            S_KROT:  if (w_done) n_state = S_KMUL1;
            S_KMUL1: if (w_done) n_state = S_KMUL2;
            S_KMUL2: begin
                if (w_done) begin
                    if (w_next == r_ek || r_iter == KW'(KEPLER_MAX_ITER - 1)) begin
                        n_state = S_FROT;
                    end else begin
                        n_state = S_KROT;
                    end
                end
            end
            S_FROT:  if (w_done) n_state = S_SQ1;
            S_SQ1:   if (w_done) n_state = S_SQRT;
            S_SQRT:  if (w_done) n_state = S_SQ2;
            S_SQ2:   if (w_done) n_state = S_VEC;
            S_VEC:   if (w_done) n_state = S_F1;
            S_F1:    if (w_done) n_state = S_R;
            S_R:     if (w_done) n_state = S_N1;
            S_N1:    if (w_done) n_state = S_N2;
            S_N2:    if (w_done) n_state = S_ROTU;
            S_ROTU:  if (w_done) n_state = S_ROTI;
            S_ROTI:  if (w_done) n_state = S_ROTL;
            S_ROTL:  if (w_done) n_state = S_P1;
            S_P1:    if (w_done) n_state = S_P2;
            S_P2:    if (w_done) n_state = S_P3;
            S_P3:    if (w_done) n_state = S_P4;
            S_P4:    if (w_done) n_state = S_P5;
            S_P5:    if (w_done) n_state = S_P6;
            S_P6:    if (w_done) n_state = S_P7;
            S_P7:    if (w_done) n_state = S_P8;
            S_P8:    if (w_done) n_state = S_OUT;
            S_OUT:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Unit requests. Each working state issues one request and then waits
    // for the unit's done pulse.
    always_comb begin
        mul_req       = '0;
        cor_req       = '0;
        ds_req        = '0;
        cor_req.ang   = r_ek;
        cor_req.y     = r_vy;
        cor_req.x     = r_ce - $signed({15'd0, r_in.eccentricity, 9'd0});
        ds_req.den    = r_s3;
        ds_req.rad    = r_rad;
        unique case (r_state)
            S_MM1: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_in.root_semi_axis);
                mul_req.b     = 64'(r_in.root_semi_axis);
            end
            S_MM2: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_s2);
                mul_req.b     = 64'(r_in.root_semi_axis);
            end
            S_DIV:  ds_req.start = !r_issued;
            S_MA: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_n;
                mul_req.b     = 64'(r_tk);
            end
            S_KROT, S_FROT: cor_req.start = !r_issued;
            S_KMUL1: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_in.eccentricity);
                mul_req.b     = 64'(r_se);
            end
            S_KMUL2: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_p14;
                mul_req.b     = INV_PI_Q32;
            end
            S_SQ1: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_in.eccentricity);
                mul_req.b     = 64'(r_in.eccentricity);
            end
            S_SQRT: begin
                ds_req.start = !r_issued;
                ds_req.sqrt  = 1'b1;
            end
            S_SQ2: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_sq);
                mul_req.b     = 64'(r_se);
            end
            S_VEC: begin
                cor_req.start = !r_issued;
                cor_req.vect  = 1'b1;
            end
            S_F1: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_in.eccentricity);
                mul_req.b     = 64'(r_ce);
            end
            S_R: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_s2);
                mul_req.b     = 64'(r_f);
            end
            S_N1: begin
                mul_req.start = !r_issued;
                mul_req.a     = NODE_RATE_Q32;
                mul_req.b     = 64'(r_tk);
            end
            S_N2: begin
                mul_req.start = !r_issued;
                mul_req.a     = EARTH_RATE_Q32;
                mul_req.b     = 64'(r_in.reference_time);
            end
            S_ROTU: begin
                cor_req.start = !r_issued;
                cor_req.ang   = r_uk;
            end
            S_ROTI: begin
                cor_req.start = !r_issued;
                cor_req.ang   = r_in.inclination;
            end
            S_ROTL: begin
                cor_req.start = !r_issued;
                cor_req.ang   = r_lam;
            end
            S_P1: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_r);
                mul_req.b     = 64'(r_cu);
            end
            S_P2: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_r);
                mul_req.b     = 64'(r_su);
            end
            S_P3: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_yp);
                mul_req.b     = 64'(r_ci);
            end
            S_P4: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_xp);
                mul_req.b     = 64'(r_cl);
            end
            S_P5: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_yc);
                mul_req.b     = 64'(r_sl);
            end
            S_P6: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_xp);
                mul_req.b     = 64'(r_sl);
            end
            S_P7: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_yc);
                mul_req.b     = 64'(r_cl);
            end
            S_P8: begin
                mul_req.start = !r_issued;
                mul_req.a     = 64'(r_yp);
                mul_req.b     = 64'(r_si);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_issued <= 1'b0;
            end else if (mul_req.start || cor_req.start || ds_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input capture on accept, output capture on load and result capture on each unit's done pulse.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in   <= i_in_data;
            r_tk   <= w_tk[31:0];
            r_conv <= 1'b0;
        end
        if (w_load) begin
            r_out.pos_x     <= r_px;
            r_out.pos_y     <= r_py;
            r_out.pos_z     <= sat32(r_t);
            r_out.converged <= r_conv;
        end
        if (w_done) begin
            unique case (r_state)
                S_MM1:  r_s2 <= mul_rsp.p[47:0];
                S_MM2:  r_s3 <= mul_rsp.p[71:0];
                S_DIV:  r_n  <= ds_rsp.q;
                S_MA: begin
                    r_m    <= r_in.mean_anomaly + mul_rsp.p[55:24];
                    r_ek   <= r_in.mean_anomaly + mul_rsp.p[55:24];
                    r_iter <= '0;
                end
                S_KROT, S_FROT: begin
                    r_ce <= cor_rsp.x;
                    r_se <= cor_rsp.y;
                end
                S_KMUL1: r_p14 <= w_lo >>> 14;
                S_KMUL2: begin
                    r_ek   <= w_next;
                    r_iter <= r_iter + 1'b1;
                    if (w_next == r_ek) begin
                        r_conv <= 1'b1;
                    end
                end
                S_SQ1:  r_rad <= 64'h1000_0000_0000_0000 - {mul_rsp.p[45:0], 18'd0};
                S_SQRT: r_sq  <= ds_rsp.q[31:0];
                S_SQ2:  r_vy  <= TRIG_W'(w_lo >>> 30);
                S_VEC:  r_uk  <= cor_rsp.z + PERIGEE_ARG;
                S_F1:   r_f   <= w_f[31:0];
                S_R:    r_r   <= mul_rsp.p[79:48];
                S_N1:   r_acc <= w_lo;
                S_N2:   r_lam <= r_in.node_longitude + w_acc[63:32];
                S_ROTU: begin
                    r_cu <= cor_rsp.x;
                    r_su <= cor_rsp.y;
                end
                S_ROTI: begin
                    r_ci <= cor_rsp.x;
                    r_si <= cor_rsp.y;
                end
                S_ROTL: begin
                    r_cl <= cor_rsp.x;
                    r_sl <= cor_rsp.y;
                end
                S_P1:   r_xp <= TRIG_W'(w_lo >>> 30);
                S_P2:   r_yp <= TRIG_W'(w_lo >>> 30);
                S_P3:   r_yc <= TRIG_W'(w_lo >>> 30);
                S_P4:   r_t  <= w_lo;
                S_P5:   r_px <= sat32(w_diff >>> 30);
                S_P6:   r_t  <= w_lo;
                S_P7:   r_py <= sat32(w_sum >>> 30);
                S_P8:   r_t  <= w_lo >>> 30;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A unit answers only a request that the sequencer has issued.
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_issued)
        else $error("unit done without an issued request");

    // The sequencer never waits on a unit while idle.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_issued)
        else $error("request outstanding while idle");

    // An accepted beat starts the computation in the next cycle.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MM1))
        else $error("accepted beat did not start the sequence");

    // A result is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("pending result overwritten");

endmodule
